// ===== rtl/core/kst_pkg.sv =====
// shared types and constants for the keyed semaphore table
// no dependencies
package kst_pkg;

    localparam int SEM_ENTRIES = 32;
    localparam int USER_SLOTS  = 16;
    localparam int EW = $clog2(SEM_ENTRIES);
    localparam int SW = $clog2(USER_SLOTS);
    localparam int UW = EW + SW;
    localparam int USER_DEPTH = SEM_ENTRIES * USER_SLOTS;

    typedef enum logic [3:0] {
        K_CREATE   = 4'd0,
        K_GETID    = 4'd1,
        K_GET      = 4'd2,
        K_SET      = 4'd3,
        K_DELETE   = 4'd4,
        K_GETCOUNT = 4'd5,
        K_DOWN     = 4'd6,
        K_UP       = 4'd7,
        K_TRYLOCK  = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOENT      = 3'd1,
        ST_ACCES      = 3'd2,
        ST_NOSPACE    = 3'd3,
        ST_EXISTS     = 3'd4,
        ST_WOULDBLOCK = 3'd5,
        ST_BUSY       = 3'd6,
        ST_DROPFAIL   = 3'd7
    } status_t;

endpackage

// ===== rtl/core/kst_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/keyed_semaphore_table_top.sv =====
// keyed semaphore table top: request sequencer, entry tables and user slot ram
// depends on kst_pkg and kst_ram
// create/getid run a full key scan over all SEM_ENTRIES entries; indexed requests
// scan the user slots through the registered ram read; rejects go straight to the result
// one request at a time: the next is taken the cycle after the result transaction
// reset: async active low, clears active bits, counters and all user valid bits
module keyed_semaphore_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  kind,
    input  logic [7:0]  requester_pid,
    input  logic [4:0]  sem_index,
    input  logic [31:0] sem_key,
    input  logic [15:0] load_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] result_value,
    output logic        wake_waiters
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KSCAN = 6'b000010,
        S_USCAN = 6'b000100,
        S_UWAIT = 6'b001000,
        S_EXEC  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [kst_pkg::SW:0] SLOTS = (kst_pkg::SW+1)'(kst_pkg::USER_SLOTS);
    localparam logic [kst_pkg::EW:0] ENTS  = (kst_pkg::EW+1)'(kst_pkg::SEM_ENTRIES);

    state_t state_reg, state_next;

    logic [3:0]  kind_reg;
    logic [7:0]  pid_reg;
    logic [kst_pkg::EW-1:0] idx_reg;
    logic [31:0] key_reg;
    logic [15:0] load_reg;

    logic [kst_pkg::SEM_ENTRIES-1:0] active_reg;
    logic [31:0] key_tab_reg   [kst_pkg::SEM_ENTRIES];
    logic [7:0]  owner_tab_reg [kst_pkg::SEM_ENTRIES];
    logic [15:0] cnt_tab_reg   [kst_pkg::SEM_ENTRIES];
    logic [kst_pkg::USER_SLOTS-1:0] uvalid_reg [kst_pkg::SEM_ENTRIES];

    logic [kst_pkg::EW:0] ecnt_reg;
    logic [kst_pkg::SW:0] scnt_reg;
    logic                 rd_pend_reg;
    logic [kst_pkg::SW-1:0] rd_slot_reg;
    logic                 kfound_reg, ffound_reg;
    logic [kst_pkg::EW-1:0] kidx_reg, fidx_reg;
    logic                 ufound_reg;
    logic [kst_pkg::SW-1:0] uslot_reg;

    logic        ovalid_reg;
    logic [2:0]  status_reg;
    logic [15:0] value_reg;
    logic        wake_reg;

    logic                   ram_we;
    logic [kst_pkg::UW-1:0] ram_addr;
    logic [7:0]             ram_rdata;

    logic [kst_pkg::EW-1:0] ecur;
    logic                   in_acc, out_acc, uses_idx, idx_bad;
    logic [kst_pkg::USER_SLOTS-1:0] uv_cur, free_mask;
    logic                   free_any;
    logic [kst_pkg::SW-1:0] free_slot;
    logic                   access;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;

    assign ecur = ecnt_reg[kst_pkg::EW-1:0];
    assign uv_cur = uvalid_reg[idx_reg];
    assign free_mask = ~uv_cur;
    assign free_any = |free_mask;
    assign access = (owner_tab_reg[idx_reg] == pid_reg) || ufound_reg;

    always_comb
    begin
        free_slot = '0;
        for (int i = kst_pkg::USER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_slot = kst_pkg::SW'(i);
            end
        end
    end

    assign uses_idx = (kind >= 4'(kst_pkg::K_GET)) && (kind <= 4'(kst_pkg::K_TRYLOCK));
    assign idx_bad = ({1'b0, sem_index} >= 6'(kst_pkg::SEM_ENTRIES))
                     || !active_reg[sem_index[kst_pkg::EW-1:0]];

    assign ram_we = (state_reg == S_EXEC) && (kind_reg == 4'(kst_pkg::K_GET))
                    && !access && free_any;
    assign ram_addr = ram_we ? {idx_reg, free_slot}
                             : {idx_reg, scnt_reg[kst_pkg::SW-1:0]};

    kst_ram #(.WIDTH(8), .DEPTH(kst_pkg::USER_DEPTH)) u_user_pid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pid_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind == 4'(kst_pkg::K_CREATE) || kind == 4'(kst_pkg::K_GETID))
                    begin
                        state_next = S_KSCAN;
                    end
                    else if (uses_idx && !idx_bad)
                    begin
                        state_next = S_USCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_KSCAN:
            begin
                if (ecnt_reg == ENTS - 1'b1)
                begin
                    state_next = S_EXEC;
                end
            end
            S_USCAN:
            begin
                if (scnt_reg == SLOTS - 1'b1)
                begin
                    state_next = S_UWAIT;
                end
            end
            S_UWAIT: state_next = S_EXEC;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            active_reg  <= '0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < kst_pkg::SEM_ENTRIES; i++)
            begin
                cnt_tab_reg[i] <= '0;
                uvalid_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_acc)
            begin
                ovalid_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == S_USCAN);
            rd_slot_reg <= scnt_reg[kst_pkg::SW-1:0];
            if (rd_pend_reg && uv_cur[rd_slot_reg] && ram_rdata == pid_reg && !ufound_reg)
            begin
                ufound_reg <= 1'b1;
                uslot_reg  <= rd_slot_reg;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        kind_reg <= kind;
                        pid_reg  <= requester_pid;
                        idx_reg  <= sem_index[kst_pkg::EW-1:0];
                        key_reg  <= sem_key;
                        load_reg <= load_value;
                        ecnt_reg <= '0;
                        scnt_reg <= '0;
                        kfound_reg <= 1'b0;
                        ffound_reg <= 1'b0;
                        ufound_reg <= 1'b0;
                        status_reg <= kst_pkg::ST_NOENT;
                        value_reg  <= '0;
                        wake_reg   <= 1'b0;
                    end
                end
                S_KSCAN:
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    if (active_reg[ecur] && key_tab_reg[ecur] == key_reg && !kfound_reg)
                    begin
                        kfound_reg <= 1'b1;
                        kidx_reg   <= ecur;
                    end
                    if (!active_reg[ecur] && !ffound_reg)
                    begin
                        ffound_reg <= 1'b1;
                        fidx_reg   <= ecur;
                    end
                end
                S_USCAN:
                begin
                    scnt_reg <= scnt_reg + 1'b1;
                end
                S_EXEC:
                begin
                    status_reg <= kst_pkg::ST_OK;
                    case (kind_reg)
                        4'(kst_pkg::K_CREATE):
                        begin
                            if (kfound_reg)
                            begin
                                status_reg <= kst_pkg::ST_EXISTS;
                            end
                            else if (!ffound_reg)
                            begin
                                status_reg <= kst_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                active_reg[fidx_reg]    <= 1'b1;
                                key_tab_reg[fidx_reg]   <= key_reg;
                                owner_tab_reg[fidx_reg] <= pid_reg;
                                uvalid_reg[fidx_reg]    <= '0;
                                value_reg <= 16'(fidx_reg);
                            end
                        end
                        4'(kst_pkg::K_GETID):
                        begin
                            if (kfound_reg)
                            begin
                                value_reg <= 16'(kidx_reg);
                            end
                            else
                            begin
                                status_reg <= kst_pkg::ST_NOENT;
                            end
                        end
                        4'(kst_pkg::K_GET):
                        begin
                            if (access)
                            begin
                                value_reg <= 16'(idx_reg);
                            end
                            else if (free_any)
                            begin
                                uvalid_reg[idx_reg][free_slot] <= 1'b1;
                                value_reg <= 16'(idx_reg);
                            end
                            else
                            begin
                                status_reg <= kst_pkg::ST_NOSPACE;
                            end
                        end
                        default:
                        begin
                            if (!access)
                            begin
                                status_reg <= kst_pkg::ST_ACCES;
                            end
                            else
                            begin
                                case (kind_reg)
                                    4'(kst_pkg::K_SET):
                                        cnt_tab_reg[idx_reg] <= load_reg;
                                    4'(kst_pkg::K_DELETE):
                                    begin
                                        if (owner_tab_reg[idx_reg] == pid_reg)
                                        begin
                                            active_reg[idx_reg] <= 1'b0;
                                        end
                                        else
                                        begin
                                            uvalid_reg[idx_reg][uslot_reg] <= 1'b0;
                                        end
                                    end
                                    4'(kst_pkg::K_GETCOUNT):
                                        value_reg <= cnt_tab_reg[idx_reg];
                                    4'(kst_pkg::K_UP):
                                    begin
                                        if (cnt_tab_reg[idx_reg] != 16'hFFFF)
                                        begin
                                            cnt_tab_reg[idx_reg] <= cnt_tab_reg[idx_reg] + 1'b1;
                                        end
                                        wake_reg <= 1'b1;
                                    end
                                    default:
                                    begin
                                        if (cnt_tab_reg[idx_reg] == '0)
                                        begin
                                            status_reg <= (kind_reg == 4'(kst_pkg::K_DOWN))
                                                ? kst_pkg::ST_WOULDBLOCK : kst_pkg::ST_BUSY;
                                        end
                                        else
                                        begin
                                            cnt_tab_reg[idx_reg] <= cnt_tab_reg[idx_reg] - 1'b1;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                S_DONE:
                begin
                    ovalid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = ovalid_reg;
    assign status       = status_reg;
    assign result_value = value_reg;
    assign wake_waiters = wake_reg;

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake_waiters) |-> (status == 3'(kst_pkg::ST_OK)))
        else $error("wake without success");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != 3'(kst_pkg::ST_OK)) |-> (result_value == '0))
        else $error("value on failure");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result not posted");
`endif

endmodule
